// ----- design/trre_pkg.sv -----
package trre_pkg;

	// Widths of the configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	// Defaults and reset values.
	localparam int        DEFAULT_BLOCK_SIZE = 512;
	localparam logic [15:0] RESET_SERVER_PORT = 16'd69;
	localparam logic [3:0]  RESET_RETRY_LIMIT = 4'd5;
	localparam logic [3:0]  RETRY_MAX         = 4'hF;

	// TFTP opcodes that the engine acts on.
	localparam logic [15:0] TFTP_DATA  = 16'd3;
	localparam logic [15:0] TFTP_ERROR = 16'd5;

	// Header bytes in front of the payload.
	localparam logic [15:0] HDR_BYTES = 16'd4;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SERVER_ADDR = 2'd0,
		REG_SERVER_PORT = 2'd1,
		REG_RETRY_LIMIT = 2'd2,
		REG_UNUSED      = 2'd3
	} cfg_reg_t;

	// Event kinds on the input channel.
	typedef enum logic [1:0] {
		OP_START    = 2'd0,
		OP_PACKET   = 2'd1,
		OP_TIMEOUT  = 2'd2,
		OP_RESERVED = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [2:0] {
		STAT_WAITING    = 3'd0,
		STAT_DATA_OK    = 3'd1,
		STAT_SERVER_ERR = 3'd2,
		STAT_RETRY_OUT  = 3'd3,
		STAT_WRONG_SRV  = 3'd4,
		STAT_BAD_BLOCK  = 3'd5,
		STAT_SHORT      = 3'd6,
		STAT_INACTIVE   = 3'd7
	} status_t;

	// Packet to transmit.
	typedef enum logic [1:0] {
		SEND_NONE = 2'd0,
		SEND_RRQ  = 2'd1,
		SEND_ACK  = 2'd2
	} send_kind_t;

	// Session state.
	typedef enum logic {
		SESS_IDLE   = 1'b0,
		SESS_ACTIVE = 1'b1
	} sess_state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] pkt_opcode;
		logic [15:0] pkt_word;
		logic [15:0] pkt_length;
		logic [31:0] src_addr;
		logic [15:0] src_port;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  send_kind;
		logic [15:0] send_block;
		logic [15:0] dest_port;
		logic [9:0]  data_length;
		logic        last_block;
		logic [15:0] error_code;
	} out_item_t;

	typedef struct packed {
		logic [31:0] server_addr;
		logic [15:0] server_port;
		logic [3:0]  retry_limit;
	} cfg_t;

	typedef struct packed {
		sess_state_t state;
		logic [15:0] block_number;
		logic [15:0] peer_port;
		logic [3:0]  retry_count;
	} sess_t;

endpackage

// ----- design/trre_if.sv -----
// Input event channel.
interface trre_in_if;
	import trre_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// Result channel.
interface trre_out_if;
	import trre_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- design/trre_cfg.sv -----
module trre_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [trre_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [trre_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output trre_pkg::cfg_t                 cfg
);
	import trre_pkg::*;

	cfg_t cfg_q;

	// Register file; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.server_addr <= '0;
			cfg_q.server_port <= RESET_SERVER_PORT;
			cfg_q.retry_limit <= RESET_RETRY_LIMIT;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SERVER_ADDR: cfg_q.server_addr <= cfg_wdata;
				REG_SERVER_PORT: cfg_q.server_port <= cfg_wdata[15:0];
				REG_RETRY_LIMIT: cfg_q.retry_limit <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/trre_step.sv -----
module trre_step #(
	parameter int BLOCK_SIZE = trre_pkg::DEFAULT_BLOCK_SIZE
) (
	input  trre_pkg::in_item_t  item,
	input  trre_pkg::cfg_t      cfg,
	input  trre_pkg::sess_t     sess,
	output trre_pkg::sess_t     sess_next,
	output trre_pkg::out_item_t res
);
	import trre_pkg::*;

	localparam logic [15:0] BLK = 16'(BLOCK_SIZE);

	logic [3:0]  retry_inc;
	logic        retry_out;
	logic [15:0] expect_blk;
	logic [15:0] payload;
	logic        short_pl;
	logic [15:0] dlen;

	// Shared retry bookkeeping; the counter saturates at its maximum.
	assign retry_inc  = (sess.retry_count != RETRY_MAX) ? sess.retry_count + 4'd1
	                                                     : sess.retry_count;
	assign retry_out  = (retry_inc >= cfg.retry_limit);
	assign expect_blk = sess.block_number + 16'd1;
	assign payload    = item.pkt_length - HDR_BYTES;
	assign short_pl   = (payload < BLK);
	assign dlen       = short_pl ? payload : BLK;

	// One event advances the session by at most one step.
	always_comb begin
		sess_next = sess;
		res       = '0;
		case (op_t'(item.operation))
			OP_START: begin
				sess_next.state        = SESS_ACTIVE;
				sess_next.block_number = '0;
				sess_next.retry_count  = '0;
				sess_next.peer_port    = cfg.server_port;
				res.status             = STAT_WAITING;
				res.send_kind          = SEND_RRQ;
				res.dest_port          = cfg.server_port;
			end
			OP_TIMEOUT: begin
				if (sess.state != SESS_ACTIVE) begin
					res.status = STAT_INACTIVE;
				end else begin
					sess_next.retry_count = retry_inc;
					if (retry_out) begin
						sess_next.state = SESS_IDLE;
						res.status      = STAT_RETRY_OUT;
					end else if (sess.block_number == '0) begin
						res.send_kind = SEND_RRQ;
						res.dest_port = sess.peer_port;
					end else begin
						res.send_kind  = SEND_ACK;
						res.send_block = sess.block_number;
						res.dest_port  = sess.peer_port;
					end
				end
			end
			OP_PACKET: begin
				if (sess.state != SESS_ACTIVE) begin
					res.status = STAT_INACTIVE;
				end else if (item.pkt_length < HDR_BYTES) begin
					sess_next.state = SESS_IDLE;
					res.status      = STAT_SHORT;
				end else if (item.src_addr != cfg.server_addr) begin
					sess_next.state = SESS_IDLE;
					res.status      = STAT_WRONG_SRV;
				end else begin
					// The server's reply port is adopted before the opcode check.
					sess_next.peer_port = item.src_port;
					if (item.pkt_opcode == TFTP_ERROR) begin
						sess_next.state = SESS_IDLE;
						res.status      = STAT_SERVER_ERR;
						res.error_code  = item.pkt_word;
					end else if (item.pkt_opcode == TFTP_DATA &&
					             item.pkt_word == expect_blk) begin
						sess_next.block_number = item.pkt_word;
						sess_next.retry_count  = '0;
						if (short_pl) begin
							sess_next.state = SESS_IDLE;
						end
						res.status      = STAT_DATA_OK;
						res.send_kind   = SEND_ACK;
						res.send_block  = item.pkt_word;
						res.dest_port   = item.src_port;
						res.data_length = dlen[9:0];
						res.last_block  = short_pl;
					end else if (item.pkt_opcode == TFTP_DATA &&
					             item.pkt_word != sess.block_number) begin
						sess_next.state = SESS_IDLE;
						res.status      = STAT_BAD_BLOCK;
					end else begin
						// Duplicate block resends and a foreign opcode waits; both count as a retry.
						sess_next.retry_count = retry_inc;
						if (retry_out) begin
							sess_next.state = SESS_IDLE;
							res.status      = STAT_RETRY_OUT;
						end else if (item.pkt_opcode != TFTP_DATA) begin
							res.status = STAT_WAITING;
						end else if (sess.block_number == '0) begin
							res.send_kind = SEND_RRQ;
							res.dest_port = item.src_port;
						end else begin
							res.send_kind  = SEND_ACK;
							res.send_block = sess.block_number;
							res.dest_port  = item.src_port;
						end
					end
				end
			end
			default: begin
				res.status = (sess.state == SESS_ACTIVE) ? STAT_WAITING : STAT_INACTIVE;
			end
		endcase
	end

endmodule

// ----- design/tftp_read_receive_engine_unit.sv -----
// TFTP read-transfer receive engine, client side.
//
// Events enter on in_ch (start, received packet header, response timeout) and
// each one gives exactly one result on out_ch: a status, the packet to send
// (read request or ACK with its block number and destination port), the
// accepted payload length and last-block flag, and the server's error code.
// Configuration (server address, server port, retry limit) is written through
// cfg_we/cfg_index/cfg_wdata; the user must write it only while no event is in
// flight, and the block itself does not enforce this.
//
// An event taken from in_ch lands in the input register; its result is
// computed by single-level compare-and-update logic and loaded into the result
// register once that register is free or drains, which raises out_ch.valid.
// One event per cycle is sustained while out_ch does not stall: the session
// state register is updated when the result is loaded, ready for the following event.
// If out_ch is stalled, the result register holds and the input register
// fills; in_ch.ready then falls until the result is taken.
// Reset (arst_n low) empties both registers, sets the session idle with block
// number, peer port and retry count zero, and restores the configuration
// defaults (server port 69, retry limit 5).
module tftp_read_receive_engine_unit #(
	parameter int BLOCK_SIZE = trre_pkg::DEFAULT_BLOCK_SIZE
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [trre_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [trre_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	trre_in_if.sink                          in_ch,
	trre_out_if.source                       out_ch
);
	import trre_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_s2;
	logic      valid_s2;
	sess_t     sess_q;
	sess_t     sess_next;
	out_item_t res_next;
	logic      adv;

	trre_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	trre_step #(
		.BLOCK_SIZE (BLOCK_SIZE)
	) u_step (
		.item      (item_s1),
		.cfg       (cfg),
		.sess      (sess_q),
		.sess_next (sess_next),
		.res       (res_next)
	);

	// The input register moves on whenever the result register is free or drains.
	assign adv         = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_ch.data;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_next;
		end
	end

	// Session state advances with each event that reaches the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sess_q.state        <= SESS_IDLE;
			sess_q.block_number <= '0;
			sess_q.peer_port    <= '0;
			sess_q.retry_count  <= '0;
		end else if (adv) begin
			sess_q <= sess_next;
		end
	end

	assign out_ch.valid = valid_s2;
	assign out_ch.data  = res_s2;

	// A start always leaves the session active with a fresh block count.
	a_start_activates: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.operation == OP_START |=>
			sess_q.state == SESS_ACTIVE && sess_q.block_number == '0)
		else $error("start did not activate the session");

	// Events other than start leave an idle session untouched.
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		adv && sess_q.state == SESS_IDLE && item_s1.operation != OP_START |=>
			$stable(sess_q))
		else $error("idle session changed");

	// A held event is never dropped while the result side is stalled.
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("pending event lost");

	// An accepted block always carries an ACK of that block.
	a_ack_on_data: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_next.status == STAT_DATA_OK |=>
			res_s2.send_kind == SEND_ACK && res_s2.send_block == sess_q.block_number)
		else $error("accepted block not acknowledged");

	// A timeout that keeps the session going leaves the retry count under the limit.
	a_retry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		adv && sess_next.state == SESS_ACTIVE && item_s1.operation == OP_TIMEOUT |->
			sess_next.retry_count < cfg.retry_limit)
		else $error("retry count passed its limit");

endmodule
